[hdl/ttqc_pkg.sv]
`timescale 1ns / 1ps

package ttqc_pkg;

  // Default sizes.
  localparam int MAX_TOKEN_LEN_DEF = 32;
  localparam int CMD_DEPTH_DEF     = 4;
  localparam int OUT_DEPTH_DEF     = 2;

  // Character codes the scanner reacts to.
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_QUOTE   = 8'h22;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] SEP_MAX      = 8'd32;

  // One command from the scanner to the token engine. The engine carries the
  // flags out in this order: clear, leading slash, store, emit, end of text.
  typedef struct packed {
    logic       clr;
    logic       pre_slash;
    logic       store;
    logic       emit;
    logic       word;
    logic       eot;
    logic [7:0] data;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [7:0] token_byte;
    logic       is_last;
    logic       is_empty;
    logic       end_of_text;
  } out_t;

endpackage

[hdl/ttqc_fifo.sv]
`timescale 1ns / 1ps

module ttqc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d;
  logic [AW-1:0]    rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Pointer and fill count update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

[hdl/ttqc_front.sv]
`timescale 1ns / 1ps

module ttqc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [7:0]          text_byte_i,
  output logic                cmd_push_o,
  output ttqc_pkg::cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    MODE_BETWEEN = 5'b00001,
    MODE_SLASH   = 5'b00010,
    MODE_COMMENT = 5'b00100,
    MODE_QUOTE   = 5'b01000,
    MODE_WORD    = 5'b10000
  } mode_e;

  mode_e          mode_q, mode_d;
  ttqc_pkg::cmd_t cmd;
  logic           is_nul, is_sep;

  assign is_nul = (text_byte_i == ttqc_pkg::CHAR_NUL);
  assign is_sep = (text_byte_i <= ttqc_pkg::SEP_MAX);

  // Classify the byte against the current mode and build its command.
  always_comb begin
    mode_d   = mode_q;
    cmd      = '0;
    cmd.data = text_byte_i;
    unique case (mode_q)
      MODE_SLASH: begin
        if (text_byte_i == ttqc_pkg::CHAR_SLASH) begin
          mode_d = MODE_COMMENT;
        end else begin
          // The held slash opens a word; this byte continues it or, as a separator, ends it.
          cmd.clr       = 1'b1;
          cmd.pre_slash = 1'b1;
          if (is_sep) begin
            cmd.emit = 1'b1;
            cmd.word = 1'b1;
            cmd.eot  = is_nul;
            mode_d   = MODE_BETWEEN;
          end else begin
            cmd.store = 1'b1;
            mode_d    = MODE_WORD;
          end
        end
      end
      MODE_COMMENT: begin
        if (text_byte_i == ttqc_pkg::CHAR_NEWLINE) begin
          mode_d = MODE_BETWEEN;
        end else if (is_nul) begin
          cmd.eot = 1'b1;
          mode_d  = MODE_BETWEEN;
        end
      end
      MODE_QUOTE: begin
        if (text_byte_i == ttqc_pkg::CHAR_QUOTE || is_nul) begin
          cmd.emit = 1'b1;
          cmd.eot  = is_nul;
          mode_d   = MODE_BETWEEN;
        end else begin
          cmd.store = 1'b1;
        end
      end
      MODE_WORD: begin
        if (is_sep) begin
          cmd.emit = 1'b1;
          cmd.word = 1'b1;
          cmd.eot  = is_nul;
          mode_d   = MODE_BETWEEN;
        end else begin
          cmd.store = 1'b1;
        end
      end
      default: begin
        // Between tokens.
        mode_d = MODE_BETWEEN;
        if (is_nul) begin
          cmd.eot = 1'b1;
        end else if (is_sep) begin
          mode_d = MODE_BETWEEN;
        end else if (text_byte_i == ttqc_pkg::CHAR_SLASH) begin
          mode_d = MODE_SLASH;
        end else if (text_byte_i == ttqc_pkg::CHAR_QUOTE) begin
          cmd.clr = 1'b1;
          mode_d  = MODE_QUOTE;
        end else begin
          cmd.clr   = 1'b1;
          cmd.store = 1'b1;
          mode_d    = MODE_WORD;
        end
      end
    endcase
  end

  assign cmd_o      = cmd;
  assign cmd_push_o = valid_i && (cmd.clr || cmd.store || cmd.emit || cmd.eot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BETWEEN;
    end else if (valid_i) begin
      mode_q <= mode_d;
    end
  end

endmodule

[hdl/ttqc_back.sv]
`timescale 1ns / 1ps

module ttqc_back #(
  parameter int MAX_TOKEN_LEN = ttqc_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ttqc_pkg::cmd_t cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o,
  input  logic           out_full_i,
  output logic           out_push_o,
  output ttqc_pkg::out_t out_item_o
);

  localparam int AW = $clog2(MAX_TOKEN_LEN);
  localparam int LW = $clog2(MAX_TOKEN_LEN + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SLASH = 6'b000010,
    ST_STORE = 6'b000100,
    ST_PREP  = 6'b001000,
    ST_EMIT  = 6'b010000,
    ST_EOT   = 6'b100000
  } bst_e;

  bst_e           state_q, state_d;
  ttqc_pkg::cmd_t cmd_q, cmd_d;
  logic [LW-1:0]  len_q, len_d;
  logic [AW-1:0]  idx_q, idx_d;
  logic [7:0]     rd_q;
  logic [7:0]     mem_q [MAX_TOKEN_LEN];
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [7:0]     wr_data;
  logic           tok_empty, idx_last, out_acc;

  // A word that filled the store is discarded; nothing stored is empty too.
  assign tok_empty = (len_q == '0) ||
                     (cmd_q.word && (len_q >= LW'(MAX_TOKEN_LEN)));
  assign idx_last  = ((LW'(idx_q) + LW'(1)) == len_q);
  assign out_acc   = out_push_o && !out_full_i;

  // Sequencer: one step of the current command per state.
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    len_d      = len_q;
    idx_d      = idx_q;
    cmd_pop_o  = 1'b0;
    out_push_o = 1'b0;
    out_item_o = '0;
    wr_en      = 1'b0;
    wr_addr    = len_q[AW-1:0];
    wr_data    = cmd_q.data;
    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          idx_d     = '0;
          if (cmd_i.clr) begin
            len_d = '0;
          end
          if (cmd_i.pre_slash) begin
            state_d = ST_SLASH;
          end else if (cmd_i.store) begin
            state_d = ST_STORE;
          end else if (cmd_i.emit) begin
            state_d = ST_EMIT;
          end else if (cmd_i.eot) begin
            state_d = ST_EOT;
          end
        end
      end
      ST_SLASH: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = ttqc_pkg::CHAR_SLASH;
        len_d   = LW'(1);
        if (cmd_q.store) begin
          state_d = ST_STORE;
        end else if (cmd_q.emit) begin
          state_d = ST_PREP;
        end else if (cmd_q.eot) begin
          state_d = ST_EOT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_STORE: begin
        if (len_q < LW'(MAX_TOKEN_LEN)) begin
          wr_en = 1'b1;
          len_d = len_q + LW'(1);
        end
        state_d = ST_IDLE;
      end
      ST_PREP: begin
        // Lets the slash just written reach the read register.
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        out_push_o = 1'b1;
        if (tok_empty) begin
          out_item_o.is_last  = 1'b1;
          out_item_o.is_empty = 1'b1;
        end else begin
          out_item_o.token_byte = rd_q;
          out_item_o.is_last    = idx_last;
        end
        if (out_acc) begin
          if (tok_empty || idx_last) begin
            len_d   = '0;
            idx_d   = '0;
            state_d = cmd_q.eot ? ST_EOT : ST_IDLE;
          end else begin
            idx_d = idx_q + AW'(1);
          end
        end
      end
      ST_EOT: begin
        out_push_o              = 1'b1;
        out_item_o.is_last      = 1'b1;
        out_item_o.end_of_text  = 1'b1;
        if (out_acc) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      idx_q   <= '0;
      cmd_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      cmd_q   <= cmd_d;
    end
  end

  // Token store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[idx_d];
  end

endmodule

[hdl/text_tokenizer_quotes_comments.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// input     in         push / full            text_byte_i
// result    out        empty / pop            token_byte_o, is_last_o, is_empty_o,
//                                             end_of_text_o
//
// The scanner takes one text byte per cycle while its command queue has room.
// The token engine writes a stored character in its store state (after its slash state
// with a held slash), gives a token out byte by byte in its emit state (entered through
// its prep state after a lone slash) and an end-of-text marker in its end-of-text state.
// Reset clears all control state; the token store needs no clearing pass.
// A stalled result port fills the result queue, then the command queue, then raises full.
module text_tokenizer_quotes_comments #(
  parameter int MAX_TOKEN_LEN = ttqc_pkg::MAX_TOKEN_LEN_DEF,
  parameter int CMD_DEPTH     = ttqc_pkg::CMD_DEPTH_DEF,
  parameter int OUT_DEPTH     = ttqc_pkg::OUT_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] token_byte_o,
  output logic       is_last_o,
  output logic       is_empty_o,
  output logic       end_of_text_o
);

  localparam int CmdW = $bits(ttqc_pkg::cmd_t);
  localparam int OutW = $bits(ttqc_pkg::out_t);

  logic           in_acc;
  logic           cmd_push, cmd_full, cmd_empty, cmd_pop;
  ttqc_pkg::cmd_t cmd_wr, cmd_rd;
  logic           out_push, out_full;
  ttqc_pkg::out_t out_wr, out_rd;

  assign full   = cmd_full;
  assign in_acc = push && !cmd_full;

  // Scanner: tracks the mode and turns bytes into commands.
  ttqc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_acc),
    .text_byte_i (text_byte_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_wr)
  );

  // Command queue between scanner and token engine.
  ttqc_fifo #(
    .WIDTH (CmdW),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_wr),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rd),
    .empty_o (cmd_empty)
  );

  // Token engine: owns the token store and produces result requests.
  ttqc_back #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_rd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_item_o  (out_wr)
  );

  // Result queue decouples the engine from the consumer.
  ttqc_fifo #(
    .WIDTH (OutW),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_wr),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_rd),
    .empty_o (empty)
  );

  assign token_byte_o  = out_rd.token_byte;
  assign is_last_o     = out_rd.is_last;
  assign is_empty_o    = out_rd.is_empty;
  assign end_of_text_o = out_rd.end_of_text;

  // The scanner never issues a command into a full queue.
  a_cmd_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !cmd_full)
    else $error("command written into a full queue");

  // The engine pops only when a command is waiting.
  a_cmd_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_empty)
    else $error("command taken from an empty queue");

  // Markers and empty tokens are single, final items with a zero byte.
  a_marker_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push && (out_wr.end_of_text || out_wr.is_empty)) |->
      (out_wr.is_last && (out_wr.token_byte == ttqc_pkg::CHAR_NUL) &&
       !(out_wr.end_of_text && out_wr.is_empty)))
    else $error("malformed marker request");

  // A request that was refused is offered again unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push && out_full) |=> (out_push && $stable(out_wr)))
    else $error("stalled result request changed");

endmodule
